// File: src/ptc_pkg.sv
// Shared types, constants and a helper function for the pressure/temperature compensation block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

   localparam int NumRegs = 6;

   localparam logic [2:0] RegOss  = 3'd0;
   localparam logic [2:0] RegAc12 = 3'd1;
   localparam logic [2:0] RegAc34 = 3'd2;
   localparam logic [2:0] RegAc56 = 3'd3;
   localparam logic [2:0] RegB12  = 3'd4;
   localparam logic [2:0] RegMcMd = 3'd5;

   localparam logic signed [31:0] TempMin  = -32'sd4096;
   localparam logic signed [31:0] TempMax  = 32'sd4095;
   localparam logic signed [31:0] PressMax = 32'sd262143;

   // Coefficients unpacked from the configuration words.
   typedef struct packed {
      logic [1:0]         oss;
      logic signed [15:0] ac1;
      logic signed [15:0] ac2;
      logic signed [15:0] ac3;
      logic [15:0]        ac4;
      logic [15:0]        ac5;
      logic [15:0]        ac6;
      logic signed [15:0] b1;
      logic signed [15:0] b2;
      logic signed [15:0] mc;
      logic signed [15:0] md;
   } coeff_type;

   // Signed divide by 2^k, truncating toward zero.
   function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] a,
                                                    input int k);
      logic signed [31:0] bias;
      bias = a[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
      return (a + bias) >>> k;
   endfunction

endpackage
`default_nettype wire

// File: src/ptc_sdiv.sv
// Pipelined restoring divider: unsigned 32/32 radix-2, one quotient bit per stage.
// Depends on nothing; the caller handles signs and zero divisors.
`timescale 1ns / 1ps
`default_nettype none
module ptc_sdiv #(
   parameter int SideW = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             valid_in,
   input  wire logic [31:0]      dividend,
   input  wire logic [31:0]      divisor,
   input  wire logic [SideW-1:0] side_in,
   output logic                  valid_out,
   output logic [31:0]           quotient,
   output logic [SideW-1:0]      side_out
);
   // Stage k resolves quotient bit 31-k; the last stage needs no remainder.
   logic [31:0]      rem_ff  [1:31];
   logic [31:0]      dvs_ff  [1:31];
   logic [31:0]      quo_ff  [1:32];
   logic [SideW-1:0] side_ff [1:32];
   logic             vld_ff  [1:32];

   for (genvar k = 0; k < 32; k++) begin : g_stage
      logic [31:0]      rem_cur;
      logic [31:0]      quo_cur;
      logic [31:0]      dvs_cur;
      logic [SideW-1:0] side_cur;
      logic             vld_cur;
      logic [32:0]      trial_in;
      logic [32:0]      diff_in;

      if (k == 0) begin : g_first
         assign rem_cur  = 32'd0;
         assign quo_cur  = dividend;
         assign dvs_cur  = divisor;
         assign side_cur = side_in;
         assign vld_cur  = valid_in;
      end else begin : g_next
         assign rem_cur  = rem_ff[k];
         assign quo_cur  = quo_ff[k];
         assign dvs_cur  = dvs_ff[k];
         assign side_cur = side_ff[k];
         assign vld_cur  = vld_ff[k];
      end

      assign trial_in = {rem_cur, quo_cur[31]};
      assign diff_in  = trial_in - {1'b0, dvs_cur};

      always_ff @(posedge clock) begin
         quo_ff[k+1]  <= {quo_cur[30:0], ~diff_in[32]};
         side_ff[k+1] <= side_cur;
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_cur;
         end
      end

      if (k < 31) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= diff_in[32] ? trial_in[31:0] : diff_in[31:0];
            dvs_ff[k+1] <= dvs_cur;
         end
      end
   end

   assign valid_out = vld_ff[32];
   assign quotient  = quo_ff[32];
   assign side_out  = side_ff[32];
endmodule
`default_nettype wire

// File: src/ptc_temp.sv
// Temperature half: X1, the MC*2048/(X1+MD) division and B5, through a pipelined divider.
// Depends on ptc_pkg and ptc_sdiv.
`timescale 1ns / 1ps
`default_nettype none
module ptc_temp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               valid,
   input  wire logic [15:0]        raw_temp,
   input  wire logic [18:0]        raw_press,
   input  wire ptc_pkg::coeff_type coeff,
   output logic                    b5_valid,
   output logic signed [31:0]      b5,
   output logic [18:0]             b5_press,
   output logic                    b5_err
);
   logic               v1_ff;
   logic signed [31:0] x1_ff;
   logic [18:0]        up1_ff;
   logic signed [31:0] prod_ff;
   logic               v0_ff;
   logic [18:0]        up0_ff;
   logic signed [31:0] diff_in;

   assign diff_in = $signed({16'd0, raw_temp}) - $signed({16'd0, coeff.ac6});

   always_ff @(posedge clock) begin
      prod_ff <= diff_in * $signed({16'd0, coeff.ac5});
      up0_ff  <= raw_press;
      x1_ff   <= ptc_pkg::sdiv_pow2(prod_ff, 15);
      up1_ff  <= up0_ff;
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= valid;
         v1_ff <= v0_ff;
      end
   end

   // Signed quotient via magnitudes; sign, x1, zero flag and raw pressure ride alongside.
   logic signed [31:0] den_in;
   logic signed [31:0] num_in;
   logic [31:0]        num_mag;
   logic [31:0]        den_mag;
   logic               zero_in;
   logic               neg_in;

   assign den_in  = x1_ff + 32'(coeff.md);
   assign num_in  = 32'(coeff.mc) <<< 11;
   assign zero_in = (den_in == 32'sd0);
   assign neg_in  = num_in[31] ^ den_in[31];
   assign num_mag = num_in[31] ? 32'(-num_in) : 32'(num_in);
   assign den_mag = zero_in ? 32'd1 : (den_in[31] ? 32'(-den_in) : 32'(den_in));

   localparam int SideW = 1 + 1 + 32 + 19;
   logic [SideW-1:0] side_out;
   logic [31:0]      quo;
   logic             div_valid;

   ptc_sdiv #(.SideW(SideW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .valid_in (v1_ff),
      .dividend (num_mag),
      .divisor  (den_mag),
      .side_in  ({zero_in, neg_in, x1_ff, up1_ff}),
      .valid_out(div_valid),
      .quotient (quo),
      .side_out (side_out)
   );

   logic signed [31:0] x2_q;
   assign x2_q = side_out[SideW-2] ? 32'(-$signed(quo)) : $signed(quo);

   always_ff @(posedge clock) begin
      b5       <= side_out[50:19] + x2_q;
      b5_press <= side_out[18:0];
      b5_err   <= side_out[SideW-1];
      if (reset) begin
         b5_valid <= 1'b0;
      end else begin
         b5_valid <= div_valid;
      end
   end
endmodule
`default_nettype wire

// File: src/ptc_press.sv
// Pressure half: B6, B3, B4, B7, the B7/B4 division, final polynomial and saturation.
// Depends on ptc_pkg and ptc_sdiv.
`timescale 1ns / 1ps
`default_nettype none
module ptc_press (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               valid,
   input  wire logic signed [31:0] b5,
   input  wire logic [18:0]        raw_press,
   input  wire logic               err_in,
   input  wire ptc_pkg::coeff_type coeff,
   output logic                    out_valid,
   output logic signed [12:0]      temperature,
   output logic [17:0]             pressure,
   output logic                    div_error
);
   // Stage a: b6, temperature, b6^2 product, ac2*b6, ac3*b6.
   logic               va_ff, ea_ff;
   logic [18:0]        upa_ff;
   logic signed [12:0] ta_ff;
   logic signed [31:0] b6a_ff, b6sq_ff, ac2b6_ff, ac3b6_ff;
   logic signed [31:0] b6_in, t_in;

   assign b6_in = b5 - 32'sd4000;
   assign t_in  = ptc_pkg::sdiv_pow2(b5 + 32'sd8, 4);

   always_ff @(posedge clock) begin
      upa_ff   <= raw_press;
      ea_ff    <= err_in;
      b6a_ff   <= b6_in;
      b6sq_ff  <= b6_in * b6_in;
      ac2b6_ff <= 32'(coeff.ac2) * b6_in;
      ac3b6_ff <= 32'(coeff.ac3) * b6_in;
      ta_ff    <= (t_in < ptc_pkg::TempMin) ? 13'(ptc_pkg::TempMin) :
                  (t_in > ptc_pkg::TempMax) ? 13'(ptc_pkg::TempMax) : 13'(t_in);
      va_ff    <= reset ? 1'b0 : valid;
   end

   // Stage b: sq, then b2*sq and b1*sq.
   logic               vb_ff, eb_ff;
   logic [18:0]        upb_ff;
   logic signed [12:0] tb_ff;
   logic signed [31:0] b2sq_ff, b1sq_ff, x2b_ff, x1c3_ff;
   logic signed [31:0] sq_in;

   assign sq_in = ptc_pkg::sdiv_pow2(b6sq_ff, 12);

   always_ff @(posedge clock) begin
      upb_ff  <= upa_ff;
      eb_ff   <= ea_ff;
      tb_ff   <= ta_ff;
      b2sq_ff <= 32'(coeff.b2) * sq_in;
      b1sq_ff <= 32'(coeff.b1) * sq_in;
      x2b_ff  <= ptc_pkg::sdiv_pow2(ac2b6_ff, 11);
      x1c3_ff <= ptc_pkg::sdiv_pow2(ac3b6_ff, 13);
      vb_ff   <= reset ? 1'b0 : va_ff;
   end

   // Stage c: b3 and x3.
   logic               vc_ff, ec_ff;
   logic [18:0]        upc_ff;
   logic signed [12:0] tc_ff;
   logic signed [31:0] b3_ff, x3_ff;
   logic signed [31:0] x3b_in, b3s_in, x3p_in;

   assign x3b_in = ptc_pkg::sdiv_pow2(b2sq_ff, 11) + x2b_ff;
   assign b3s_in = ((32'(coeff.ac1) <<< 2) + x3b_in) <<< coeff.oss;
   assign x3p_in = x1c3_ff + ptc_pkg::sdiv_pow2(b1sq_ff, 16) + 32'sd2;

   always_ff @(posedge clock) begin
      upc_ff <= upb_ff;
      ec_ff  <= eb_ff;
      tc_ff  <= tb_ff;
      b3_ff  <= ptc_pkg::sdiv_pow2(b3s_in + 32'sd2, 2);
      x3_ff  <= ptc_pkg::sdiv_pow2(x3p_in, 2);
      vc_ff  <= reset ? 1'b0 : vb_ff;
   end

   // Stage d: b4 product and b7 product.
   logic               vd_ff, ed_ff;
   logic signed [12:0] td_ff;
   logic [31:0]        b4p_ff, b7_ff;
   logic [31:0]        b7d_in;

   assign b7d_in = 32'(upc_ff) - b3_ff;

   always_ff @(posedge clock) begin
      ed_ff  <= ec_ff;
      td_ff  <= tc_ff;
      b4p_ff <= {16'd0, coeff.ac4} * (x3_ff + 32'd32768);
      b7_ff  <= b7d_in * (32'd50000 >> coeff.oss);
      vd_ff  <= reset ? 1'b0 : vc_ff;
   end

   // Divide: b4 = b4p/32768; pick dividend from b7 range.
   logic [31:0] b4_in;
   logic        b4z_in, big_in;
   assign b4_in  = b4p_ff >> 15;
   assign b4z_in = (b4_in == 32'd0);
   assign big_in = b7_ff[31];

   localparam int SideW = 1 + 1 + 13;
   logic [SideW-1:0] side_out;
   logic [31:0]      quo;
   logic             div_valid;

   ptc_sdiv #(.SideW(SideW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .valid_in (vd_ff),
      .dividend (big_in ? b7_ff : {b7_ff[30:0], 1'b0}),
      .divisor  (b4z_in ? 32'd1 : b4_in),
      .side_in  ({ed_ff | b4z_in, big_in, td_ff}),
      .valid_out(div_valid),
      .quotient (quo),
      .side_out (side_out)
   );

   // Stage e: p and (p/256)^2, -7357*p.
   logic               ve_ff, ee_ff;
   logic signed [12:0] te_ff;
   logic signed [31:0] pe_ff, pp_ff, p7_ff;
   logic signed [31:0] p_in, p8_in;

   assign p_in  = side_out[13] ? $signed({quo[30:0], 1'b0}) : $signed(quo);
   assign p8_in = ptc_pkg::sdiv_pow2(p_in, 8);

   always_ff @(posedge clock) begin
      ee_ff <= side_out[14];
      te_ff <= side_out[12:0];
      pe_ff <= p_in;
      pp_ff <= p8_in * p8_in;
      p7_ff <= -32'sd7357 * p_in;
      ve_ff <= reset ? 1'b0 : div_valid;
   end

   // Stage f: x1*3038.
   logic               vf_ff, ef_ff;
   logic signed [12:0] tf_ff;
   logic signed [31:0] pf_ff, m3_ff, x2f_ff;

   always_ff @(posedge clock) begin
      ef_ff  <= ee_ff;
      tf_ff  <= te_ff;
      pf_ff  <= pe_ff;
      m3_ff  <= pp_ff * 32'sd3038;
      x2f_ff <= ptc_pkg::sdiv_pow2(p7_ff, 16);
      vf_ff  <= reset ? 1'b0 : ve_ff;
   end

   // Stage g: final sum and saturation.
   logic signed [31:0] pfin_in;
   assign pfin_in = pf_ff + ptc_pkg::sdiv_pow2(
                       ptc_pkg::sdiv_pow2(m3_ff, 16) + x2f_ff + 32'sd3791, 4);

   always_ff @(posedge clock) begin
      div_error   <= ef_ff;
      temperature <= ef_ff ? 13'sd0 : tf_ff;
      pressure    <= ef_ff ? 18'd0 :
                     (pfin_in < 32'sd0) ? 18'd0 :
                     (pfin_in > ptc_pkg::PressMax) ? 18'(ptc_pkg::PressMax) : 18'(pfin_in);
      out_valid   <= reset ? 1'b0 : vf_ff;
   end
endmodule
`default_nettype wire

// File: src/pressure_temp_compensation.sv
// Top level of the pressure/temperature compensation pipeline.
// Depends on ptc_pkg, ptc_temp, ptc_press.
//
//   channel  ports                                   handshake
//   input    req_raw_temp, req_raw_press             start & !busy
//   result   rsp_temperature, rsp_pressure,          rsp_strobe, one cycle
//            rsp_div_error
//   config   csr_write_en, csr_index, csr_wdata      csr_write_en
//
// A new item may enter every cycle; busy is tied low. The path runs through the two
// 32-stage pipelined dividers plus ten arithmetic stages.
// Synchronous reset clears the valid chain and the calibration registers.
// The receiver cannot stall; results leave on rsp_strobe.
`timescale 1ns / 1ps
`default_nettype none
module pressure_temp_compensation (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_raw_temp,
   input  wire logic [18:0] req_raw_press,
   output logic             rsp_strobe,
   output logic signed [12:0] rsp_temperature,
   output logic [17:0]      rsp_pressure,
   output logic             rsp_div_error,
   input  wire logic        csr_write_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   logic [1:0]  oss_ff;
   logic [31:0] ac12_ff, ac34_ff, ac56_ff, b12_ff, mcmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         oss_ff  <= 2'd0;
         ac12_ff <= 32'd0;
         ac34_ff <= 32'd0;
         ac56_ff <= 32'd0;
         b12_ff  <= 32'd0;
         mcmd_ff <= 32'd0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ptc_pkg::RegOss:  oss_ff  <= csr_wdata[1:0];
            ptc_pkg::RegAc12: ac12_ff <= csr_wdata;
            ptc_pkg::RegAc34: ac34_ff <= csr_wdata;
            ptc_pkg::RegAc56: ac56_ff <= csr_wdata;
            ptc_pkg::RegB12:  b12_ff  <= csr_wdata;
            ptc_pkg::RegMcMd: mcmd_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ptc_pkg::coeff_type coeff;
   always_comb begin
      coeff.oss = oss_ff;
      coeff.ac1 = ac12_ff[31:16];
      coeff.ac2 = ac12_ff[15:0];
      coeff.ac3 = ac34_ff[31:16];
      coeff.ac4 = ac34_ff[15:0];
      coeff.ac5 = ac56_ff[31:16];
      coeff.ac6 = ac56_ff[15:0];
      coeff.b1  = b12_ff[31:16];
      coeff.b2  = b12_ff[15:0];
      coeff.mc  = mcmd_ff[31:16];
      coeff.md  = mcmd_ff[15:0];
   end

   assign busy = 1'b0;

   logic               b5_valid, b5_err;
   logic signed [31:0] b5;
   logic [18:0]        b5_press;

   ptc_temp u_temp (
      .clock    (clock),
      .reset    (reset),
      .valid    (start),
      .raw_temp (req_raw_temp),
      .raw_press(req_raw_press),
      .coeff    (coeff),
      .b5_valid (b5_valid),
      .b5       (b5),
      .b5_press (b5_press),
      .b5_err   (b5_err)
   );

   ptc_press u_press (
      .clock      (clock),
      .reset      (reset),
      .valid      (b5_valid),
      .b5         (b5),
      .raw_press  (b5_press),
      .err_in     (b5_err),
      .coeff      (coeff),
      .out_valid  (rsp_strobe),
      .temperature(rsp_temperature),
      .pressure   (rsp_pressure),
      .div_error  (rsp_div_error)
   );
endmodule
`default_nettype wire

// File: src/ptc_checker.sv
// Port-level checks for the compensation pipeline, bound to the top level.
// Depends on pressure_temp_compensation.
`timescale 1ns / 1ps
`default_nettype none
module ptc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              busy,
   input wire logic              rsp_strobe,
   input wire logic signed [12:0] rsp_temperature,
   input wire logic [17:0]       rsp_pressure,
   input wire logic              rsp_div_error
);
   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_div_error |-> rsp_temperature == 13'sd0 && rsp_pressure == 18'd0)
      else $error("error result not zero");
   a_no_strobe_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("strobe after reset");
endmodule

bind pressure_temp_compensation ptc_checker u_ptc_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_temperature(rsp_temperature),
   .rsp_pressure   (rsp_pressure),
   .rsp_div_error  (rsp_div_error)
);
`default_nettype wire

// File: dv/pressure_temp_compensation_test.sv
// Self-checking testbench for pressure_temp_compensation: a local compensation model
// predicts each reading pair's result, checked in order against the result strobe.
// Depends on ptc_pkg and the pressure_temp_compensation RTL.
`timescale 1ns / 1ps
module pressure_temp_compensation_test;

   typedef struct {
      logic signed [12:0] temperature;
      logic [17:0]        pressure;
      logic               div_error;
   } reading_type;

   localparam int IntMin = 32'h8000_0000;
   localparam logic [2:0] RegSpare6 = 3'd6;
   localparam logic [2:0] RegSpare7 = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_raw_temp = '0;
   logic [18:0] req_raw_press = '0;
   logic        rsp_strobe;
   logic signed [12:0] rsp_temperature;
   logic [17:0] rsp_pressure;
   logic        rsp_div_error;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // shadow of the calibration registers
   logic [1:0]  oss_shadow;
   logic [31:0] coeff_shadow [1:5];

   reading_type expected_readings [$];
   int          mismatch_count = 0;
   int          readings_checked = 0;
   int          error_readings = 0;
   int          items_sent = 0;
   bit          idle_enabled = 1'b1;

   pressure_temp_compensation u_top (
      .clock, .reset, .start, .busy, .req_raw_temp, .req_raw_press,
      .rsp_strobe, .rsp_temperature, .rsp_pressure, .rsp_div_error,
      .csr_write_en, .csr_index, .csr_wdata
   );

   always #5 clock = ~clock;

   function automatic int div_trunc(int a, int d);
      if (a == IntMin && d == -1) return IntMin;
      return a / d;
   endfunction

   function automatic reading_type compensate(logic [15:0] ut_in, logic [18:0] up_in);
      reading_type r;
      int ac1, ac2, ac3, b1, b2, mc, md, ac5, ac6, ut;
      int x1, x2, x3, b5, b6, sq, b3, p, temp;
      int unsigned ac4, up, b4, b7, pu, scale;
      ac1 = int'($signed(coeff_shadow[1][31:16]));
      ac2 = int'($signed(coeff_shadow[1][15:0]));
      ac3 = int'($signed(coeff_shadow[2][31:16]));
      ac4 = {16'd0, coeff_shadow[2][15:0]};
      ac5 = int'({16'd0, coeff_shadow[3][31:16]});
      ac6 = int'({16'd0, coeff_shadow[3][15:0]});
      b1  = int'($signed(coeff_shadow[4][31:16]));
      b2  = int'($signed(coeff_shadow[4][15:0]));
      mc  = int'($signed(coeff_shadow[5][31:16]));
      md  = int'($signed(coeff_shadow[5][15:0]));
      ut  = int'({16'd0, ut_in});
      up  = {13'd0, up_in};
      r = '{temperature: '0, pressure: '0, div_error: 1'b0};
      x1 = div_trunc((ut - ac6) * ac5, 32768);
      x2 = x1 + md;
      if (x2 == 0) begin
         r.div_error = 1'b1;
         return r;
      end
      x2 = div_trunc(mc * 2048, x2);
      b5 = x1 + x2;
      temp = div_trunc(b5 + 8, 16);
      b6 = b5 - 4000;
      sq = div_trunc(b6 * b6, 4096);
      x1 = div_trunc(b2 * sq, 2048);
      x2 = div_trunc(ac2 * b6, 2048);
      x3 = x1 + x2;
      b3 = (ac1 * 4 + x3) << oss_shadow;
      b3 = div_trunc(b3 + 2, 4);
      x1 = div_trunc(ac3 * b6, 8192);
      x2 = div_trunc(b1 * sq, 65536);
      x3 = div_trunc(x1 + x2 + 2, 4);
      b4 = (ac4 * (int'(x3) + 32'd32768)) / 32'd32768;
      if (b4 == 0) begin
         r.div_error = 1'b1;
         return r;
      end
      scale = 32'd50000 >> oss_shadow;
      b7 = (up - b3) * scale;
      if (b7 < 32'h8000_0000) pu = (b7 * 2) / b4;
      else pu = (b7 / b4) * 2;
      p = int'(pu);
      x1 = div_trunc(p, 256) * div_trunc(p, 256);
      x1 = div_trunc(x1 * 3038, 65536);
      x2 = div_trunc(-7357 * p, 65536);
      p = p + div_trunc(x1 + x2 + 3791, 16);
      if (temp < ptc_pkg::TempMin) temp = ptc_pkg::TempMin;
      else if (temp > ptc_pkg::TempMax) temp = ptc_pkg::TempMax;
      if (p < 0) p = 0;
      else if (p > ptc_pkg::PressMax) p = ptc_pkg::PressMax;
      r.temperature = temp[12:0];
      r.pressure = p[17:0];
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_strobe) begin
         if (expected_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: T=%0d P=%0d E=%0b", rsp_temperature,
                        rsp_pressure, rsp_div_error);
         end else begin
            want = expected_readings.pop_front();
            readings_checked++;
            if (want.div_error) error_readings++;
            if (rsp_temperature !== want.temperature || rsp_pressure !== want.pressure ||
                rsp_div_error !== want.div_error) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected T=%0d P=%0d E=%0b, got T=%0d P=%0d E=%0b",
                           want.temperature, want.pressure, want.div_error,
                           rsp_temperature, rsp_pressure, rsp_div_error);
            end
         end
      end
   end

   task automatic write_reg(logic [2:0] index, logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      if (index == ptc_pkg::RegOss) oss_shadow = data[1:0];
      else if (index <= ptc_pkg::RegMcMd) coeff_shadow[index] = data;
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // typical calibration words, optionally jittered
   task automatic load_typical(logic [1:0] oss, bit jitter);
      logic [31:0] j;
      j = jitter ? {8'd0, 8'($urandom_range(0, 255)), 8'd0, 8'($urandom_range(0, 255))} : '0;
      write_reg(ptc_pkg::RegOss, {30'd0, oss});
      write_reg(ptc_pkg::RegAc12, {16'sd408, -16'sd72} ^ j);
      write_reg(ptc_pkg::RegAc34, {-16'sd14383, 16'd32741} ^ j);
      write_reg(ptc_pkg::RegAc56, {16'd32757, 16'd23153} ^ j);
      write_reg(ptc_pkg::RegB12, {16'sd6190, 16'sd4} ^ j);
      write_reg(ptc_pkg::RegMcMd, {-16'sd8711, 16'sd2868} ^ j);
   endtask

   task automatic send_reading(logic [15:0] ut, logic [18:0] up);
      start <= 1'b1;
      req_raw_temp <= ut;
      req_raw_press <= up;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_readings.push_back(compensate(ut, up));
      items_sent++;
      if (idle_enabled && $urandom_range(0, 99) < 3) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic test_reset_state;
      // all-zero calibration: the temperature divisor is zero
      send_reading(16'd0, 19'd0);
      send_reading(16'hFFFF, 19'h7FFFF);
      drain();
   endtask

   task automatic test_zero_divisors;
      load_typical(2'd0, 1'b0);
      write_reg(ptc_pkg::RegAc56, {16'd0, 16'd23153});
      write_reg(ptc_pkg::RegMcMd, {-16'sd8711, 16'sd0});
      send_reading(16'd27898, 19'd23843);
      drain();
      write_reg(ptc_pkg::RegAc56, {16'd32757, 16'd23153});
      write_reg(ptc_pkg::RegMcMd, {-16'sd8711, 16'sd2868});
      write_reg(ptc_pkg::RegAc34, {-16'sd14383, 16'd0});
      send_reading(16'd27898, 19'd23843);
      send_reading(16'd1, 19'd1);
      drain();
   endtask

   task automatic test_field_extremes;
      for (int o = 0; o < 4; o++) begin
         load_typical(o[1:0], 1'b0);
         send_reading(16'd27898, 19'd23843 << o);
         send_reading(16'd0, 19'd0);
         send_reading(16'hFFFF, 19'h7FFFF);
         send_reading(16'h8000, 19'h40000);
         drain();
      end
      // extreme coefficients and spare register indexes
      write_reg(ptc_pkg::RegOss, 32'hFFFF_FFFF);
      write_reg(RegSpare6, 32'hDEAD_BEEF);
      write_reg(RegSpare7, 32'h1234_5678);
      write_reg(ptc_pkg::RegAc12, 32'h8000_7FFF);
      write_reg(ptc_pkg::RegAc34, 32'h7FFF_FFFF);
      write_reg(ptc_pkg::RegAc56, 32'hFFFF_0000);
      write_reg(ptc_pkg::RegB12, 32'h8000_8000);
      write_reg(ptc_pkg::RegMcMd, 32'h7FFF_8001);
      send_reading(16'hFFFF, 19'h7FFFF);
      send_reading(16'd0, 19'd0);
      drain();
   endtask

   task automatic test_random_phases;
      for (int ph = 0; ph < 10; ph++) begin
         idle_enabled = (ph != 3);
         if (ph % 3 == 2) begin
            write_reg(ptc_pkg::RegOss, $urandom());
            for (int k = 1; k <= 5; k++) write_reg(k[2:0], $urandom());
         end else
            load_typical(2'($urandom_range(0, 3)), ph != 0);
         for (int n = 0; n < 192; n++) begin
            if ($urandom_range(0, 3) == 0)
               send_reading(16'($urandom()), 19'($urandom()));
            else
               send_reading(16'(16'd27898 + $urandom_range(0, 8000) - 16'd4000),
                            19'((19'd23843 + $urandom_range(0, 30000)) << oss_shadow));
            if (n == 96 && ph == 5) begin
               // hold off until the pipeline has emptied
               start <= 1'b0;
               @(posedge clock);
               while (expected_readings.size() != 0) @(posedge clock);
            end
         end
         drain();
      end
      idle_enabled = 1'b1;
   endtask

   initial begin
      oss_shadow = '0;
      for (int k = 1; k <= 5; k++) coeff_shadow[k] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_zero_divisors();
      test_field_extremes();
      test_random_phases();
      drain();
      repeat (100) @(posedge clock);
      $display("%0d reading pairs sent, %0d results checked (%0d with divide errors),",
               items_sent, readings_checked, error_readings);
      $display("over all oversampling levels and typical, jittered and random coefficients");
      if (mismatch_count == 0 && expected_readings.size() == 0)
         $display("pressure_temp_compensation test passed");
      else
         $display("pressure_temp_compensation test failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("pressure_temp_compensation test failed");
      $finish;
   end

endmodule
